@@ src/ttt_pkg.sv @@
// Shared types and codes for the task timer table.
`default_nettype none
package ttt_pkg;
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_ADD    = 3'd1,
		OP_REMOVE = 3'd2,
		OP_POLL   = 3'd3,
		OP_SET    = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_FULL    = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  task_id;
		logic [31:0] first_delay;
		logic [31:0] period;
		logic [31:0] param_a;
		logic [31:0] param_b;
		logic [31:0] time_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        dispatch_valid;
		logic [7:0]  run_task_id;
		logic [31:0] run_param_a;
		logic [31:0] run_param_b;
		logic [31:0] time_now;
	} rsp_t;

	// Per-cell command, broadcast by the controller in the update cycle.
	typedef struct packed {
		logic tick;
		logic load;      // the cell at the fill point takes the new task
		logic drop;      // cells at or past drop_pos shift toward index 0
		logic clr_pend;  // clear pending at hit position
	} cell_cmd_t;
endpackage
`default_nettype wire

@@ src/ttt_if.sv @@
// Valid/ready channel interface.
`default_nettype none
interface ttt_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/ttt_cell.sv @@
// One task slot: holds its entry and takes its upper neighbor's entry on a shift.
`default_nettype none
module ttt_cell #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ttt_pkg::cell_cmd_t   cmd,
	input  wire logic                 is_fill,
	input  wire logic                 is_hit,
	input  wire logic                 shift_in,
	input  wire logic                 nb_used,
	input  wire logic                 nb_pend,
	input  wire logic [7:0]           nb_handle,
	input  wire logic [TIME_BITS-1:0] nb_count,
	input  wire logic [TIME_BITS-1:0] nb_period,
	input  wire logic [31:0]          nb_arg_a,
	input  wire logic [31:0]          nb_arg_b,
	input  wire logic [7:0]           ld_handle,
	input  wire logic [TIME_BITS-1:0] ld_count,
	input  wire logic [TIME_BITS-1:0] ld_period,
	input  wire logic [31:0]          ld_arg_a,
	input  wire logic [31:0]          ld_arg_b,
	output logic                      used_q,
	output logic                      pend_q,
	output logic [7:0]                handle_q,
	output logic [TIME_BITS-1:0]      count_q,
	output logic [TIME_BITS-1:0]      period_q,
	output logic [31:0]               arg_a_q,
	output logic [31:0]               arg_b_q
);
	import ttt_pkg::*;

	logic                 zero;
	logic [TIME_BITS-1:0] base;

	assign zero = (count_q == '0);
	assign base = (zero && period_q != '0) ? period_q : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (cmd.tick && used_q) begin
			pend_q <= pend_q | zero;
		end else if (cmd.load && is_fill) begin
			used_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (cmd.drop && shift_in) begin
			used_q <= nb_used;
			pend_q <= nb_pend & nb_used;
		end else if (cmd.clr_pend && is_hit) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick && used_q) begin
			count_q <= base - 1'b1;
		end else if (cmd.load && is_fill) begin
			handle_q <= ld_handle;
			count_q  <= ld_count;
			period_q <= ld_period;
			arg_a_q  <= ld_arg_a;
			arg_b_q  <= ld_arg_b;
		end else if (cmd.drop && shift_in) begin
			handle_q <= nb_handle;
			count_q  <= nb_count;
			period_q <= nb_period;
			arg_a_q  <= nb_arg_a;
			arg_b_q  <= nb_arg_b;
		end
	end
endmodule
`default_nettype wire

@@ src/tick_task_timer_table_core.sv @@
// Top level: slot chain plus the operation controller.
// Each operation is accepted into req_s1; once the result register can take a
// result, the chain is searched, the cells are updated and the result is registered.
// A new request is accepted only after the previous one has updated; the result
// register frees while the next request is searched.
// arst_n clears all slots, the scan point, the time counter and handshakes.
`default_nettype none
module tick_task_timer_table_core #(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	ttt_if.sink      req,
	ttt_if.source    rsp
);
	import ttt_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	logic                 used    [MAX_TASKS];
	logic                 pend    [MAX_TASKS];
	logic [7:0]           handle  [MAX_TASKS];
	logic [TIME_BITS-1:0] count   [MAX_TASKS];
	logic [TIME_BITS-1:0] period  [MAX_TASKS];
	logic [31:0]          arg_a   [MAX_TASKS];
	logic [31:0]          arg_b   [MAX_TASKS];

	req_t        req_s1;
	logic        busy_s1;
	logic [IW-1:0] scan_q;
	logic [31:0] time_q;
	rsp_t        rsp_q;
	logic        rsp_vld_q;

	cell_cmd_t   cmd;
	logic [CW-1:0] n;
	logic        found_id;
	logic [IW-1:0] id_pos;
	logic        found_p;
	logic [IW-1:0] p_pos;
	logic [IW-1:0] start;
	logic [IW-1:0] drop_pos;
	logic [IW-1:0] n_idx;
	logic        upd;
	rsp_t        rsp_d;
	logic [IW-1:0] scan_d;
	logic [31:0] time_d;

	assign req.ready = !busy_s1;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	// update only when the result register can take the new result
	assign upd = busy_s1 && (!rsp_vld_q || rsp.ready);

	// Fill count and handle match over the chain.
	always_comb begin
		n = '0;
		found_id = 1'b0;
		id_pos = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (used[i]) n = CW'(i + 1);
			if (used[i] && handle[i] == req_s1.task_id && !found_id) begin
				found_id = 1'b1;
				id_pos = IW'(i);
			end
		end
	end

	assign n_idx = n[IW-1:0];
	assign start = (CW'(scan_q) < n) ? scan_q : '0;

	// Round search: first pending at or after start, else first pending.
	always_comb begin
		logic hi_f;
		logic [IW-1:0] hi_p, lo_p;
		logic lo_f;
		hi_f = 1'b0; lo_f = 1'b0; hi_p = '0; lo_p = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (used[i] && pend[i]) begin
				if (IW'(i) >= start && !hi_f) begin
					hi_f = 1'b1; hi_p = IW'(i);
				end
				if (!lo_f) begin
					lo_f = 1'b1; lo_p = IW'(i);
				end
			end
		end
		found_p = hi_f | lo_f;
		p_pos = hi_f ? hi_p : lo_p;
	end

	logic do_add, do_rem, do_poll, one_shot;
	assign one_shot = (period[p_pos] == '0);
	assign do_add  = upd && req_s1.opcode == OP_ADD && !found_id
		&& n < CW'(MAX_TASKS);
	assign do_rem  = upd && req_s1.opcode == OP_REMOVE && found_id;
	assign do_poll = upd && req_s1.opcode == OP_POLL && found_p;
	assign drop_pos = do_rem ? id_pos : p_pos;

	always_comb begin
		cmd.tick     = upd && req_s1.opcode == OP_TICK;
		cmd.load     = do_add;
		cmd.drop     = do_rem || (do_poll && one_shot);
		cmd.clr_pend = do_poll;
	end

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		localparam int NB = (g + 1 < MAX_TASKS) ? g + 1 : g;
		ttt_cell #(.TIME_BITS(TIME_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.is_fill  (n_idx == IW'(g)),
			.is_hit   (p_pos == IW'(g)),
			.shift_in (IW'(g) >= drop_pos),
			.nb_used  ((g + 1 < MAX_TASKS) ? used[NB] : 1'b0),
			.nb_pend  (pend[NB]),
			.nb_handle(handle[NB]),
			.nb_count (count[NB]),
			.nb_period(period[NB]),
			.nb_arg_a (arg_a[NB]),
			.nb_arg_b (arg_b[NB]),
			.ld_handle(req_s1.task_id),
			.ld_count (TIME_BITS'(req_s1.first_delay)),
			.ld_period(TIME_BITS'(req_s1.period)),
			.ld_arg_a (req_s1.param_a),
			.ld_arg_b (req_s1.param_b),
			.used_q   (used[g]),
			.pend_q   (pend[g]),
			.handle_q (handle[g]),
			.count_q  (count[g]),
			.period_q (period[g]),
			.arg_a_q  (arg_a[g]),
			.arg_b_q  (arg_b[g])
		);
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) req_s1 <= req.data;
	end

	// Result, scan point and time for the request held in req_s1.
	always_comb begin
		rsp_d = '0;
		rsp_d.status = ST_OK;
		rsp_d.time_now = time_q;
		scan_d = scan_q;
		time_d = time_q;
		if (busy_s1) begin
			unique case (req_s1.opcode)
				OP_TICK: begin
					time_d = time_q + 32'd1;
					rsp_d.time_now = time_q + 32'd1;
				end
				OP_ADD: begin
					if (found_id) rsp_d.status = ST_DUP;
					else if (n >= CW'(MAX_TASKS)) rsp_d.status = ST_FULL;
				end
				OP_REMOVE: begin
					if (found_id) begin
						if (scan_q > id_pos) begin
							if (CW'(scan_q - 1'b1) >= n - 1'b1) scan_d = '0;
							else scan_d = scan_q - 1'b1;
						end else if (CW'(scan_q) >= n - 1'b1) begin
							scan_d = '0;
						end
					end
				end
				OP_POLL: begin
					if (!found_p) begin
						rsp_d.status = ST_NONE;
					end else begin
						rsp_d.dispatch_valid = 1'b1;
						rsp_d.run_task_id    = handle[p_pos];
						rsp_d.run_param_a    = arg_a[p_pos];
						rsp_d.run_param_b    = arg_b[p_pos];
						if (one_shot) begin
							scan_d = (CW'(p_pos) >= n - 1'b1) ? '0 : p_pos;
						end else begin
							scan_d = (CW'(p_pos) + 1'b1 < n) ? p_pos + 1'b1 : '0;
						end
					end
				end
				OP_SET: begin
					time_d = req_s1.time_value;
					rsp_d.time_now = req_s1.time_value;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			rsp_vld_q <= 1'b0;
			scan_q    <= '0;
			time_q    <= '0;
			rsp_q     <= '0;
		end else begin
			if (req.valid && req.ready) busy_s1 <= 1'b1;
			else if (upd) busy_s1 <= 1'b0;
			if (upd) begin
				rsp_vld_q <= 1'b1;
				rsp_q     <= rsp_d;
				scan_q    <= scan_d;
				time_q    <= time_d;
			end else if (rsp.valid && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/ttt_checker.sv @@
// Port-level checks for the task timer table, bound to the top level.
`default_nettype none
module ttt_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         req_valid,
	input wire logic         req_ready,
	input wire logic         rsp_valid,
	input wire logic         rsp_ready,
	input wire ttt_pkg::rsp_t rsp_data
);
	import ttt_pkg::*;

	// Dispatch only with ok status.
	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.dispatch_valid |-> rsp_data.status == ST_OK)
		else $error("dispatch with non-ok status");
	// No task id without a dispatch.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.dispatch_valid |-> rsp_data.run_task_id == '0)
		else $error("task id without dispatch");
	// Back-to-back accepts never happen.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("accept in consecutive cycles");
	// Result stays while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");
endmodule

bind tick_task_timer_table_core ttt_checker u_ttt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);
`default_nettype wire
